@@ design/ostl_pkg.sv @@
`timescale 1ns / 1ps
package ostl_pkg;
	localparam int DataWidthDef = 32;
	localparam int FracBitsDef  = 16;
	localparam int GainW        = 16;
	localparam int CfgW         = 48;
	localparam int CfgIdxW      = 2;
	localparam int MemDepth     = 64;
	localparam int MemAw        = 6;
	localparam logic [CfgW-1:0] GainReset = 48'h0100_0100_0100;

	localparam logic [2:0] SlotMass  = 3'd0;
	localparam logic [2:0] SlotJac   = 3'd1;
	localparam logic [2:0] SlotCor   = 3'd2;
	localparam logic [2:0] SlotGrav  = 3'd3;
	localparam logic [2:0] SlotAcc   = 3'd4;
	localparam logic [2:0] SlotPerr  = 3'd5;
	localparam logic [2:0] SlotVerr  = 3'd6;
	localparam logic [2:0] SlotJvel  = 3'd7;

	localparam logic [1:0] RegKp = 2'd0;
	localparam logic [1:0] RegKd = 2'd1;
	localparam logic [1:0] RegDamp = 2'd2;
	localparam logic [1:0] RegFric = 2'd3;

	localparam logic OpLoad    = 1'b0;
	localparam logic OpCompute = 1'b1;

	// memory map: matrices at 0 and 16, vectors in groups of four from 32
	function automatic logic [MemAw-1:0] vec_addr(input logic [2:0] slot, input logic [1:0] el);
		logic [MemAw-1:0] base;
		begin
			base = '0;
			case (slot)
				SlotCor:  base = MemAw'(32);
				SlotGrav: base = MemAw'(36);
				SlotAcc:  base = MemAw'(40);
				SlotPerr: base = MemAw'(44);
				SlotVerr: base = MemAw'(48);
				SlotJvel: base = MemAw'(52);
				default:  base = '0;
			endcase
			vec_addr = base + MemAw'(el);
		end
	endfunction

	function automatic logic [MemAw-1:0] mat_addr(input logic [2:0] slot, input logic [3:0] el);
		mat_addr = (slot == SlotMass) ? MemAw'(el) : MemAw'(16) + MemAw'(el);
	endfunction
endpackage

@@ design/ostl_ram.sv @@
`timescale 1ns / 1ps
module ostl_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/ostl_mac.sv @@
`timescale 1ns / 1ps
// Multiply, floor shift, saturate; registered product.
module ostl_mac import ostl_pkg::*; #(
	parameter int DataWidth = DataWidthDef
) (
	input  logic                        clk,
	input  logic signed [DataWidth:0]   a,
	input  logic signed [DataWidth:0]   b,
	input  logic [4:0]                  sh,
	output logic signed [DataWidth-1:0] p_s1,
	output logic                        clip_s1
);
	localparam int PW = 2 * DataWidth + 2;
	logic signed [PW-1:0] prod, shd;
	logic signed [DataWidth-1:0] maxv, minv;
	always_comb begin
		prod = PW'(a) * PW'(b);
		shd  = prod >>> sh;
		maxv = {1'b0, {(DataWidth-1){1'b1}}};
		minv = {1'b1, {(DataWidth-1){1'b0}}};
	end
	always_ff @(posedge clk) begin
		if (shd > PW'(maxv)) begin
			p_s1 <= maxv; clip_s1 <= 1'b1;
		end else if (shd < PW'(minv)) begin
			p_s1 <= minv; clip_s1 <= 1'b1;
		end else begin
			p_s1 <= shd[DataWidth-1:0]; clip_s1 <= 1'b0;
		end
	end
endmodule

@@ design/operational_space_torque_law_core.sv @@
`timescale 1ns / 1ps
// Operational-space torque law core.
// Input channel (valid/ready): op=0 stores one operand word (slot, element,
// value) into the operand RAM; out-of-range elements are dropped.
// op=1 runs the torque law and emits three words (joint 0,1,2; last on 2).
// A compute word walks one sequencer over one shared multiplier: each step
// addresses the RAM (S_RD), multiplies (S_MUL) and accumulates (S_ACC);
// plain adds skip the multiply. The joints come out in order, and no further
// input word is taken until the last joint has been emitted; the single RAM
// read port and the single multiplier serialise the steps.
// Loads are accepted back to back while idle.
// Output channel (valid/ready): one output register; the sequencer waits while
// a torque is not taken, so stalls lose nothing and add their length.
// Reset clears the gain registers to 1.0 and runs a clearing pass over all 64
// words of the operand RAM, during which no input word is accepted.
// Config: cfg_we/cfg_index/cfg_data, written while idle (the user must keep to this; the block does not enforce it).
module operational_space_torque_law_core import ostl_pkg::*; #(
	parameter int DATA_WIDTH = DataWidthDef,
	parameter int FRAC_BITS  = FracBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [2:0]                   slot,
	input  logic [3:0]                   element,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   joint,
	output logic signed [DATA_WIDTH-1:0] torque,
	output logic                         saturated,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [CfgIdxW-1:0]           cfg_index,
	input  logic [CfgW-1:0]              cfg_data
);
	localparam int DW = DATA_WIDTH;
	localparam int AW = DW + 4;
	localparam logic signed [AW-1:0] MaxA = AW'({1'b0, {(DW-1){1'b1}}});
	localparam logic signed [AW-1:0] MinA = -AW'({1'b0, {(DW-1){1'b1}}}) - AW'(1);

	typedef enum logic [5:0] {
		S_CLR = 6'b000001, S_IDLE = 6'b000010, S_RD = 6'b000100,
		S_MUL = 6'b001000, S_ACC = 6'b010000, S_OUT = 6'b100000
	} state_t;
	state_t state_q;

	logic [CfgW-1:0] kp_q, kd_q, dmp_q, fr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= GainReset; kd_q <= GainReset; dmp_q <= GainReset; fr_q <= GainReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKp:   kp_q  <= cfg_data;
				RegKd:   kd_q  <= cfg_data;
				RegDamp: dmp_q <= cfg_data;
				RegFric: fr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// RAM holds the operands; v and w kept in registers.
	logic we; logic [MemAw-1:0] waddr, raddr; logic [DW-1:0] wdata;
	logic signed [DW-1:0] rdata;
	ostl_ram #(.Width(DW), .Depth(MemDepth)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata);

	logic [MemAw-1:0] clr_q;
	logic [1:0] ph_q, i_q, j_q; // phase: 0 v, 1 w, 2 u
	logic [1:0] t_q;            // term index inside an entry
	logic signed [DW-1:0] v_q [3], w_q [3];
	logic signed [AW-1:0] acc_q;
	logic shared_q, f_q;
	logic signed [DW:0] ma, mb; logic [4:0] msh;
	logic signed [DW-1:0] p; logic pclip;

	ostl_mac #(.DataWidth(DW)) u_mac (.clk, .a(ma), .b(mb), .sh(msh), .p_s1(p), .clip_s1(pclip));

	logic load_ok;
	always_comb begin
		load_ok = (slot <= SlotJac) ? (element <= 4'd8) : (element <= 4'd2);
		in_ready = (state_q == S_IDLE);
		we = 1'b0; waddr = '0; wdata = '0;
		if (state_q == S_CLR) begin
			we = 1'b1; waddr = clr_q;
		end else if (in_valid && in_ready && op == OpLoad && load_ok) begin
			we = 1'b1; wdata = value;
			waddr = (slot <= SlotJac) ? mat_addr(slot, element) : vec_addr(slot, element[1:0]);
		end
	end

	function automatic logic [15:0] g16(input logic [CfgW-1:0] r, input logic [1:0] ax);
		g16 = r[{ax, 4'd0} +: 16];
	endfunction

	// term schedule; phase v: t0 acc, t1 kd*de, t2 kp*e
	// phase w: t0 cor, t1 grav, t2..: L*v (j over 3) -> use j_q as inner
	// phase u: J^T*w (summed over j), then damp, friction
	// address is held through the step, so the registered rdata is valid from the state after S_RD on
	always_comb begin
		raddr = '0;
		unique case (ph_q)
			2'd0: begin
				case (t_q)
					2'd0: raddr = vec_addr(SlotAcc, i_q);
					2'd1: raddr = vec_addr(SlotVerr, i_q);
					default: raddr = vec_addr(SlotPerr, i_q);
				endcase
			end
			2'd1: begin
				case (t_q)
					2'd0: raddr = vec_addr(SlotCor, i_q);
					2'd1: raddr = vec_addr(SlotGrav, i_q);
					default: raddr = mat_addr(SlotMass, 4'(i_q * 3 + j_q));
				endcase
			end
			default: begin
				case (t_q)
					2'd0: raddr = mat_addr(SlotJac, 4'(j_q * 3 + i_q));
					default: raddr = vec_addr(SlotJvel, i_q);
				endcase
			end
		endcase
	end

	// step counter: ph0: t 0..2; ph1: t0,t1, then t=2 with j 0..2; ph2: t0 with j 0..2, t1 damp, t2 fric
	logic use_mul, direct;
	logic signed [DW-1:0] sgn;
	always_comb begin
		ma = '0; mb = '0; msh = 5'd8; use_mul = 1'b1; direct = 1'b0;
		sgn = (rdata > 0) ? DW'(1) <<< FRAC_BITS : ((rdata < 0) ? -(DW'(1) <<< FRAC_BITS) : '0);
		unique case (ph_q)
			2'd0: begin
				if (t_q == 2'd0) begin use_mul = 1'b0; direct = 1'b1; end
				else begin
					ma = (DW+1)'({1'b0, g16(t_q == 2'd1 ? kd_q : kp_q, i_q)});
					mb = (DW+1)'(rdata);
				end
			end
			2'd1: begin
				if (t_q != 2'd2) begin use_mul = 1'b0; direct = 1'b1; end
				else begin ma = (DW+1)'(rdata); mb = (DW+1)'(v_q[j_q]); msh = 5'(FRAC_BITS); end
			end
			default: begin
				if (t_q == 2'd0) begin
					ma = (DW+1)'(rdata); mb = (DW+1)'(w_q[j_q]); msh = 5'(FRAC_BITS);
				end else if (t_q == 2'd1) begin
					ma = (DW+1)'({1'b0, g16(dmp_q, i_q)}); mb = (DW+1)'(rdata);
				end else begin
					ma = (DW+1)'(sgn); mb = (DW+1)'({1'b0, g16(fr_q, i_q)});
				end
			end
		endcase
	end

	logic signed [AW-1:0] nacc, sacc;
	logic nclip;
	always_comb begin
		if (direct) nacc = acc_q + AW'(rdata);
		else if (ph_q == 2'd2 && t_q != 2'd0) nacc = acc_q - AW'(p);
		else nacc = acc_q + AW'(p);
		sacc = (acc_q > MaxA) ? MaxA : ((acc_q < MinA) ? MinA : acc_q);
		nclip = (acc_q > MaxA) || (acc_q < MinA);
	end

	logic last_term;
	always_comb begin
		unique case (ph_q)
			2'd0: last_term = (t_q == 2'd2);
			2'd1: last_term = (t_q == 2'd2) && (j_q == 2'd2);
			default: last_term = (t_q == 2'd2);
		endcase
	end

	logic emit;
	assign emit = (state_q == S_OUT) && (ph_q == 2'd2) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; ph_q <= '0; i_q <= '0; j_q <= '0; t_q <= '0;
			shared_q <= 1'b0; f_q <= 1'b0; acc_q <= '0;
			joint <= '0; torque <= '0; saturated <= 1'b0; last <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MemAw'(MemDepth - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid && op == OpCompute) begin
					ph_q <= '0; i_q <= '0; j_q <= '0; t_q <= '0; acc_q <= '0;
					shared_q <= 1'b0; f_q <= 1'b0; state_q <= S_RD;
				end
				S_RD: state_q <= use_mul ? S_MUL : S_ACC;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					acc_q <= nacc;
					if (!direct) f_q <= f_q | pclip;
					if (last_term) state_q <= S_OUT;
					else begin
						state_q <= S_RD;
						if (ph_q == 2'd1 && t_q == 2'd2) j_q <= j_q + 1'b1;
						else if (ph_q == 2'd2 && t_q == 2'd0 && j_q != 2'd2) j_q <= j_q + 1'b1;
						else begin t_q <= t_q + 1'b1; j_q <= '0; end
					end
				end
				S_OUT: begin
					// acc_q holds the finished entry sum
					if (ph_q == 2'd0) begin
						t_q <= '0; j_q <= '0; acc_q <= '0;
						v_q[i_q] <= sacc[DW-1:0]; shared_q <= shared_q | f_q | nclip; f_q <= 1'b0;
						if (i_q == 2'd2) begin ph_q <= 2'd1; i_q <= '0; end else i_q <= i_q + 1'b1;
						state_q <= S_RD;
					end else if (ph_q == 2'd1) begin
						t_q <= '0; j_q <= '0; acc_q <= '0;
						w_q[i_q] <= sacc[DW-1:0]; shared_q <= shared_q | f_q | nclip; f_q <= 1'b0;
						if (i_q == 2'd2) begin ph_q <= 2'd2; i_q <= '0; end else i_q <= i_q + 1'b1;
						state_q <= S_RD;
					end else if (emit) begin
						t_q <= '0; j_q <= '0; acc_q <= '0;
						joint <= i_q; torque <= sacc[DW-1:0];
						saturated <= shared_q | f_q | nclip; last <= (i_q == 2'd2);
						f_q <= 1'b0;
						if (i_q == 2'd2) state_q <= S_IDLE;
						else begin i_q <= i_q + 1'b1; state_q <= S_RD; end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/ostl_checker.sv @@
`timescale 1ns / 1ps
module ostl_checker (
	input logic clk, input logic arst_n,
	input logic in_valid, input logic in_ready,
	input logic out_valid, input logic out_ready,
	input logic [1:0] joint, input logic last
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (joint == 2'd2))) else $error("last mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(joint)) else $error("output dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready || last) else $error("accepted during run");
endmodule
bind operational_space_torque_law_core ostl_checker u_chk (.*);
